// ===== src/ffsc_pkg.sv =====
package ffsc_pkg;

    localparam int NUM_FINGERS = 4;
    localparam int SAMPLE_BITS = 12;
    localparam int FINGER_W    = 2;
    localparam int CFG_W       = 12;
    localparam int CNT_W       = 5;
    localparam int MEAN_W      = 16;
    localparam int FORCE_W     = 8;
    localparam int PWM_W       = 12;
    localparam int ACC_W       = 32;
    localparam int MUL_A_W     = 17;
    localparam int MUL_B_W     = 15;
    localparam int DIVD_W      = 30;
    localparam int DIVS_W      = 14;
    localparam int DCNT_W      = 5;
    localparam int STEP_DIVD_W = 13;
    localparam int MEAN_NUM_W  = 30;
    localparam int PROD_W      = 2 * MEAN_NUM_W;

    // The mean dividend stays below 2**30, so a multiply by ceil(2**43 / 10000)
    // and a shift by 43 gives the exact floor of the division by 10000.
    localparam logic [MEAN_NUM_W-1:0] MEAN_RECIP       = 30'd879609303;
    localparam int                    MEAN_RECIP_SHIFT = 43;

    localparam logic [DCNT_W-1:0] STEP_DIV_BITS = 5'd13;

    localparam logic signed [MUL_B_W-1:0] MEAN_KEEP = 15'sd9000;

    localparam logic [PWM_W-1:0] PWM_STOP       = 12'd375;
    localparam logic [PWM_W-1:0] PWM_MIN_STEP   = 12'd10;
    localparam logic [PWM_W-1:0] PWM_MAX_STEP   = 12'd20;
    localparam logic [PWM_W-1:0] PWM_PULL_EXTRA = 12'd10;
    localparam logic [PWM_W-1:0] PWM_DISABLED   = 12'd0;

    localparam logic [CNT_W-1:0] PULL_LIMIT = CNT_W'(PWM_MAX_STEP + PWM_PULL_EXTRA);
    localparam logic [CNT_W-1:0] PUSH_LIMIT = CNT_W'(PWM_MAX_STEP);
    localparam logic signed [MUL_B_W-1:0] PULL_FACTOR =
        MUL_B_W'(PWM_MAX_STEP + PWM_PULL_EXTRA - PWM_MIN_STEP);
    localparam logic signed [MUL_B_W-1:0] PUSH_FACTOR =
        MUL_B_W'(PWM_MAX_STEP - PWM_MIN_STEP);

    typedef enum logic [1:0] {
        CFG_UPPER_LIMIT = 2'd0,
        CFG_LOWER_LIMIT = 2'd1,
        CFG_STALL_TOL   = 2'd2,
        CFG_STALL_LIMIT = 2'd3
    } t_cfg_index;

    typedef enum logic [3:0] {
        S_IDLE,
        S_STALL,
        S_MAC,
        S_SCALE,
        S_MEAN,
        S_DECIDE,
        S_DIV_STEP,
        S_WAIT_STEP,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                start;
        logic [DIVD_W-1:0]   dividend;
        logic [DIVS_W-1:0]   divisor;
        logic [DCNT_W-1:0]   nbits;
    } t_div_req;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [DIVD_W-1:0]   quotient;
    } t_div_sts;

    // Calibration gain in thousandths, scaled by 256 for the Q8.8 mean.
    function automatic logic [11:0] gain_x256(input logic [FINGER_W-1:0] finger);
        logic [11:0] g;
        case (finger)
            2'd0:    g = 12'd1280;
            2'd1:    g = 12'd1280;
            2'd2:    g = 12'd2560;
            2'd3:    g = 12'd1792;
            default: g = 12'd0;
        endcase
        return g;
    endfunction

    // Rounding term and calibration offset, plus 32768 times the divisor so that
    // the dividend stays positive and the quotient comes out offset by 32768.
    function automatic logic signed [ACC_W-1:0] mean_bias(input logic [FINGER_W-1:0] finger);
        logic signed [ACC_W-1:0] b;
        case (finger)
            2'd0:    b = 32'sd326917000;
            2'd1:    b = 32'sd327352200;
            2'd2:    b = 32'sd327032200;
            2'd3:    b = 32'sd327173000;
            default: b = 32'sd0;
        endcase
        return b;
    endfunction

endpackage

// ===== src/ffsc_div.sv =====
module ffsc_div
    import ffsc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_sts o_sts
);

    logic [DIVS_W-1:0] r_rem, n_rem;
    logic [DIVS_W-1:0] r_dvs, n_dvs;
    logic [DIVD_W-1:0] r_quo, n_quo;
    logic [DCNT_W-1:0] r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DIVS_W:0]   shifted;
    logic [DIVS_W+1:0] trial;

    always_comb begin
        shifted = {r_rem, r_quo[DIVD_W-1]};
        trial   = {1'b0, shifted} - {2'b00, r_dvs};
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_req.start) begin
            n_rem  = '0;
            n_dvs  = i_req.divisor;
            n_quo  = i_req.dividend;
            n_cnt  = i_req.nbits;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!trial[DIVS_W+1]) begin
                n_rem = trial[DIVS_W-1:0];
                n_quo = {r_quo[DIVD_W-2:0], 1'b1};
            end else begin
                n_rem = shifted[DIVS_W-1:0];
                n_quo = {r_quo[DIVD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - DCNT_W'(1);
            if (r_cnt == DCNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
    end

    assign o_sts.busy     = r_busy;
    assign o_sts.done     = r_done;
    assign o_sts.quotient = r_quo;

endmodule

// ===== src/finger_force_servo_controller.sv =====
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+--------------------------------------------
// cfg      | in        | i_cfg_we               | i_cfg_index, i_cfg_data
// sample   | in        | i_in_valid, o_in_stall | i_finger, i_raw_force, i_motors_enabled
// servo    | out       | o_out_valid, i_out_stall | o_servo_channel, o_pwm_value, o_drive_direction
//
// A word for a valid finger passes through five sequencer steps for the stall check, the mean
// update and the decision; when the motors are enabled and the force has not yet crossed the limit
// of the current drive direction, it also takes the restoring divider's 13-step PWM division.
// A second word is taken only after the first has been moved into the output register.
// Reset is synchronous and active low; it loads default configuration and clears per-finger state.
// A stalled result holds in the output register while the next word is processed.
module finger_force_servo_controller
    import ffsc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [FINGER_W-1:0]    i_finger,
    input  logic [SAMPLE_BITS-1:0] i_raw_force,
    input  logic                   i_motors_enabled,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [FINGER_W-1:0]    o_servo_channel,
    output logic [PWM_W-1:0]       o_pwm_value,
    output logic                   o_drive_direction
);

    t_state r_state, n_state;

    logic signed [FORCE_W-1:0] r_upper, r_lower;
    logic [11:0]               r_tol;
    logic [CNT_W-1:0]          r_limit;

    logic [SAMPLE_BITS-1:0]    r_prev [NUM_FINGERS];
    logic [CNT_W-1:0]          r_scnt [NUM_FINGERS];
    logic signed [MEAN_W-1:0]  r_mean [NUM_FINGERS];
    logic                      r_dirs [NUM_FINGERS];

    logic [FINGER_W-1:0]       r_finger, n_finger;
    logic [SAMPLE_BITS-1:0]    r_raw, n_raw;
    logic                      r_en, n_en;
    logic                      r_fvalid, n_fvalid;
    logic                      r_dir, n_dir;
    logic signed [ACC_W-1:0]   r_acc, n_acc;
    logic [PROD_W-1:0]         r_prod, n_prod;
    logic signed [MEAN_W-1:0]  r_mean_new, n_mean_new;
    logic                      r_neg, n_neg;
    logic [8:0]                r_span_mag, n_span_mag;
    logic [PWM_W-1:0]          r_pwm, n_pwm;

    logic                      r_out_valid, n_out_valid;
    logic [FINGER_W-1:0]       r_out_ch, n_out_ch;
    logic [PWM_W-1:0]          r_out_pwm, n_out_pwm;
    logic                      r_out_dir, n_out_dir;

    logic                      wr_stall, wr_mean, wr_dir;
    logic [CNT_W-1:0]          stall_cnt_w;

    t_div_req                  div_req;
    t_div_sts                  div_sts;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [ACC_W-1:0]   acc_base, product, mac_sum;

    logic [SAMPLE_BITS:0]      raw_diff;
    logic [SAMPLE_BITS-1:0]    raw_adiff;
    logic [CNT_W:0]            cnt_next;
    logic                      stall_force;

    logic [MEAN_W:0]           neg_mean;
    logic signed [FORCE_W-1:0] force_val;
    logic signed [8:0]         force9, upper9, lower9, span9, span_eff, step_diff;
    logic [8:0]                span_mag;
    logic                      move_on;

    logic [STEP_DIVD_W-1:0]    q_mag;
    logic signed [14:0]        q_s, step_s;
    logic [CNT_W-1:0]          step_lim, step_c;
    logic [MEAN_W:0]           mean_q;
    logic signed [MEAN_W-1:0]  mean_sat;

    ffsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_sts   (div_sts)
    );

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_servo_channel   = r_out_ch;
    assign o_pwm_value       = r_out_pwm;
    assign o_drive_direction = r_out_dir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper <= 8'sd4;
            r_lower <= 8'sd1;
            r_tol   <= 12'd30;
            r_limit <= 5'd20;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_UPPER_LIMIT: r_upper <= i_cfg_data[FORCE_W-1:0];
                CFG_LOWER_LIMIT: r_lower <= i_cfg_data[FORCE_W-1:0];
                CFG_STALL_TOL:   r_tol   <= i_cfg_data[11:0];
                CFG_STALL_LIMIT: r_limit <= i_cfg_data[CNT_W-1:0];
                default:         r_tol   <= r_tol;
            endcase
        end
    end

    always_comb begin
        case (r_state)
            S_STALL: begin
                mul_a    = MUL_A_W'(r_mean[r_finger]);
                mul_b    = MEAN_KEEP;
                acc_base = mean_bias(r_finger);
            end
            S_MAC: begin
                mul_a    = MUL_A_W'(r_raw);
                mul_b    = MUL_B_W'(gain_x256(r_finger));
                acc_base = r_acc;
            end
            S_DECIDE: begin
                mul_a    = MUL_A_W'(step_diff);
                mul_b    = r_dir ? PUSH_FACTOR : PULL_FACTOR;
                acc_base = '0;
            end
            default: begin
                mul_a    = '0;
                mul_b    = '0;
                acc_base = '0;
            end
        endcase
        product = mul_a * mul_b;
        mac_sum = acc_base + product;
    end

    always_comb begin
        raw_diff    = {1'b0, r_raw} - {1'b0, r_prev[r_finger]};
        raw_adiff   = raw_diff[SAMPLE_BITS] ? SAMPLE_BITS'(-raw_diff)
                                            : raw_diff[SAMPLE_BITS-1:0];
        cnt_next    = (16'(raw_adiff) < 16'(r_tol)) ? {1'b0, r_scnt[r_finger]} + 6'd1 : '0;
        stall_force = (cnt_next > {1'b0, r_limit});
        stall_cnt_w = stall_force ? '0 : cnt_next[CNT_W-1:0];

        mean_q   = r_prod[PROD_W-1:MEAN_RECIP_SHIFT];
        mean_sat = mean_q[MEAN_W] ? 16'sh7FFF
                                  : {~mean_q[MEAN_W-1], mean_q[MEAN_W-2:0]};

        neg_mean  = 17'd0 - 17'(r_mean_new);
        force_val = r_mean_new[MEAN_W-1] ? FORCE_W'(9'd0 - neg_mean[MEAN_W:8])
                                         : r_mean_new[MEAN_W-1:8];
        force9    = 9'(force_val);
        upper9    = 9'(r_upper);
        lower9    = 9'(r_lower);
        span9     = upper9 - lower9;
        span_eff  = (span9 == 9'sd0) ? 9'sd1 : span9;
        span_mag  = span_eff[8] ? 9'(-span_eff) : span_eff;
        step_diff = r_dir ? (force9 - lower9) : (upper9 - force9);
        move_on   = r_dir ? (force9 > lower9) : (force9 < upper9);

        q_mag    = div_sts.quotient[STEP_DIVD_W-1:0];
        q_s      = r_neg ? (15'sd0 - 15'(q_mag)) : 15'(q_mag);
        step_s   = q_s + 15'(PWM_MIN_STEP);
        step_lim = r_dir ? PUSH_LIMIT : PULL_LIMIT;
        if (step_s < 15'sd0) begin
            step_c = '0;
        end else if (step_s > $signed(15'(step_lim))) begin
            step_c = step_lim;
        end else begin
            step_c = step_s[CNT_W-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_finger    = r_finger;
        n_raw       = r_raw;
        n_en        = r_en;
        n_fvalid    = r_fvalid;
        n_dir       = r_dir;
        n_acc       = r_acc;
        n_prod      = r_prod;
        n_mean_new  = r_mean_new;
        n_neg       = r_neg;
        n_span_mag  = r_span_mag;
        n_pwm       = r_pwm;
        n_out_valid = r_out_valid & i_out_stall;
        n_out_ch    = r_out_ch;
        n_out_pwm   = r_out_pwm;
        n_out_dir   = r_out_dir;
        wr_stall    = 1'b0;
        wr_mean     = 1'b0;
        wr_dir      = 1'b0;
        div_req     = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_finger = i_finger;
                    n_raw    = i_raw_force;
                    n_en     = i_motors_enabled;
                    n_fvalid = ({1'b0, i_finger} < 3'(NUM_FINGERS));
                    n_state  = S_STALL;
                end
            end
            S_STALL: begin
                if (r_fvalid) begin
                    wr_stall = 1'b1;
                    n_dir    = stall_force ? 1'b0 : r_dirs[r_finger];
                    n_acc    = mac_sum;
                    n_state  = S_MAC;
                end else begin
                    n_dir   = 1'b0;
                    n_pwm   = PWM_DISABLED;
                    n_state = S_OUT;
                end
            end
            S_MAC: begin
                n_acc   = mac_sum;
                n_state = S_SCALE;
            end
            S_SCALE: begin
                n_prod  = PROD_W'(r_acc[MEAN_NUM_W-1:0]) * PROD_W'(MEAN_RECIP);
                n_state = S_MEAN;
            end
            S_MEAN: begin
                wr_mean    = 1'b1;
                n_mean_new = mean_sat;
                n_state    = S_DECIDE;
            end
            S_DECIDE: begin
                if (!r_en) begin
                    n_pwm   = PWM_DISABLED;
                    n_state = S_OUT;
                end else if (!move_on && !r_dir) begin
                    n_dir   = 1'b1;
                    n_pwm   = PWM_STOP - PWM_MIN_STEP;
                    n_state = S_OUT;
                end else if (!move_on) begin
                    n_dir   = 1'b0;
                    n_pwm   = PWM_STOP + PWM_MIN_STEP;
                    n_state = S_OUT;
                end else begin
                    n_acc      = mac_sum;
                    n_neg      = span_eff[8];
                    n_span_mag = span_mag;
                    n_state    = S_DIV_STEP;
                end
            end
            S_DIV_STEP: begin
                div_req.start    = 1'b1;
                div_req.dividend = {r_acc[STEP_DIVD_W-1:0], (DIVD_W-STEP_DIVD_W)'(0)};
                div_req.divisor  = DIVS_W'(r_span_mag);
                div_req.nbits    = STEP_DIV_BITS;
                n_state          = S_WAIT_STEP;
            end
            S_WAIT_STEP: begin
                if (div_sts.done) begin
                    n_pwm   = r_dir ? (PWM_STOP - PWM_W'(step_c)) : (PWM_STOP + PWM_W'(step_c));
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    wr_dir      = r_fvalid;
                    n_out_valid = 1'b1;
                    n_out_ch    = r_finger;
                    n_out_pwm   = r_pwm;
                    n_out_dir   = r_dir;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_finger   <= n_finger;
        r_raw      <= n_raw;
        r_en       <= n_en;
        r_fvalid   <= n_fvalid;
        r_dir      <= n_dir;
        r_acc      <= n_acc;
        r_prod     <= n_prod;
        r_mean_new <= n_mean_new;
        r_neg      <= n_neg;
        r_span_mag <= n_span_mag;
        r_pwm      <= n_pwm;
        r_out_ch   <= n_out_ch;
        r_out_pwm  <= n_out_pwm;
        r_out_dir  <= n_out_dir;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_FINGERS; i++) begin
                r_prev[i] <= '0;
                r_scnt[i] <= '0;
                r_mean[i] <= '0;
                r_dirs[i] <= 1'b0;
            end
        end else begin
            if (wr_stall) begin
                r_prev[r_finger] <= r_raw;
                r_scnt[r_finger] <= stall_cnt_w;
            end
            if (wr_mean) begin
                r_mean[r_finger] <= mean_sat;
            end
            if (wr_dir) begin
                r_dirs[r_finger] <= r_dir;
            end
        end
    end

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_sts.busy)
        else $error("divider started while busy");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_sts.done |-> (r_state == S_WAIT_STEP))
        else $error("divider finished with no sequencer waiting");

    a_wait_has_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT_STEP) |-> (div_sts.busy || div_sts.done))
        else $error("sequencer waits on an idle divider");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_OUT)
        else $error("result word appeared outside the output step");

    a_pwm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pwm_value == PWM_DISABLED ||
                         (o_pwm_value >= 12'd355 && o_pwm_value <= 12'd405)))
        else $error("PWM value out of range");

endmodule
